### rtl/core/deadline_ordered_timeout_queue_defines.svh
// Assertion macros used by the timeout queue back end.
`ifndef DEADLINE_ORDERED_TIMEOUT_QUEUE_DEFINES_SVH
`define DEADLINE_ORDERED_TIMEOUT_QUEUE_DEFINES_SVH

// Checks that a condition holds at every clock edge out of reset.
`define DOTQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define DOTQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/dotq_pkg.sv
// Shared types and constants of the deadline ordered timeout queue.
package dotq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int MAX_FIRE       = 16;
  localparam int FIRE_CW        = $clog2(MAX_FIRE + 1);
  localparam int FIRE_IW        = $clog2(MAX_FIRE);
  localparam int FIFO_DEPTH     = 2;
  localparam int MS_TO_US       = 1000;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_ARM_AT    = 3'd0,
    REQ_ARM_AFTER = 3'd1,
    REQ_DISARM    = 3'd2,
    REQ_DISARM_ALL = 3'd3,
    REQ_TICK      = 3'd4,
    REQ_QUERY     = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOREG  = 2'd1,
    ST_BADREQ = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_ARM,
    K_DIS,
    K_DALL,
    K_TICK,
    K_QUERY,
    K_STAT
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         id;
    logic signed [63:0] due;
    logic signed [63:0] now;
    logic               keep;
    logic               clr;
    status_t            status;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic        fv;
    logic [3:0]  fid;
    logic        last;
    logic        armed;
    logic [62:0] delay;
    logic        qa;
    logic        qf;
    logic [63:0] qs;
    logic [63:0] qd;
  } res_t;

endpackage

### rtl/core/deadline_ordered_timeout_queue.sv
// Top level of the deadline ordered timeout queue.
// A request is held in the front-end register, then waits in a two-entry queue.
// The back end takes one request at a time from the queue: an arm inserts the timer,
// a query captures its state and a tick pops the due timers before the result.
// A tick pops one due timer per cycle, then emits one result per fired timer.
// Synchronous active-low reset empties the timer list, flags, queue and handler mask.
module deadline_ordered_timeout_queue #(
  parameter int NUM_TIMERS = dotq_pkg::NUM_TIMERS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // timer_id[3:0], deadline[67:4], delay_ms[98:68], current_time[162:99],
  // keep_flag[163], clear_on_read[164], zero fill
  input  logic [167:0] in_tdata,
  // req_type[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // fired_id[3:0], alarm_armed[4], alarm_delay_us[67:5], query_active[68],
  // query_fired[69], query_start_time[133:70], query_deadline[197:134], zero fill
  output logic [199:0] out_tdata,
  // status[1:0], fired_valid[2]
  output logic [2:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data
);

  logic           push;
  logic           full;
  logic           empty;
  logic           pop;
  dotq_pkg::cmd_t fcmd;
  dotq_pkg::cmd_t qcmd;
  dotq_pkg::res_t res;

  dotq_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
    .clk, .rst_n,
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req        (in_tuser),
    .id         (in_tdata[3:0]),
    .deadline   (in_tdata[67:4]),
    .wait_ms    (in_tdata[98:68]),
    .now        (in_tdata[162:99]),
    .keep       (in_tdata[163]),
    .clr        (in_tdata[164]),
    .cfg_wr_en,
    .cfg_wr_data,
    .push,
    .full,
    .cmd        (fcmd)
  );

  dotq_fifo u_fifo (
    .clk, .rst_n,
    .push,
    .din   (fcmd),
    .full,
    .pop,
    .dout  (qcmd),
    .empty
  );

  dotq_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk, .rst_n,
    .cmd_valid (!empty),
    .cmd       (qcmd),
    .cmd_pop   (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res
  );

  assign out_tdata = {2'b00, res.qd, res.qs, res.qf, res.qa, res.delay, res.armed, res.fid};
  assign out_tuser = {res.fv, res.status};
  assign out_tlast = res.last;

endmodule

### rtl/core/dotq_front.sv
// Front end: accepts requests, computes deadlines and classifies them.
module dotq_front #(
  parameter int NUM_TIMERS = dotq_pkg::NUM_TIMERS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2:0]      req,
  input  logic [3:0]      id,
  input  logic [63:0]     deadline,
  input  logic [30:0]     wait_ms,
  input  logic [63:0]     now,
  input  logic            keep,
  input  logic            clr,
  input  logic            cfg_wr_en,
  input  logic [15:0]     cfg_wr_data,
  output logic            push,
  input  logic            full,
  output dotq_pkg::cmd_t  cmd
);

  logic        s1_v_r;
  logic [2:0]  s1_req_r;
  logic [3:0]  s1_id_r;
  logic [63:0] s1_dl_r;
  logic [63:0] s1_now_r;
  logic        s1_keep_r;
  logic        s1_clr_r;
  logic [40:0] s1_prod_r;
  logic [15:0] mask_r;

  logic [64:0] sum;
  logic        sat;
  logic        valid_id;
  logic        regd;

  assign push     = s1_v_r && !full;
  assign in_ready = !s1_v_r || push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      mask_r <= '0;
    end else begin
      if (cfg_wr_en) mask_r <= cfg_wr_data;
      if (in_valid && in_ready) begin
        s1_v_r    <= 1'b1;
        s1_req_r  <= req;
        s1_id_r   <= id;
        s1_dl_r   <= deadline;
        s1_now_r  <= now;
        s1_keep_r <= keep;
        s1_clr_r  <= clr;
        s1_prod_r <= 41'(wait_ms) * 41'(dotq_pkg::MS_TO_US);
      end else if (push) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // The product is non-negative, so the sum cannot fall below the signed minimum.
  assign sum      = {s1_now_r[63], s1_now_r} + {24'b0, s1_prod_r};
  assign sat      = !sum[64] && sum[63];
  assign valid_id = 32'(s1_id_r) < NUM_TIMERS;
  assign regd     = valid_id && mask_r[s1_id_r];

  always_comb begin
    cmd.id     = s1_id_r;
    cmd.now    = s1_now_r;
    cmd.keep   = s1_keep_r;
    cmd.clr    = s1_clr_r;
    cmd.due    = s1_dl_r;
    cmd.status = dotq_pkg::ST_OK;
    cmd.kind   = dotq_pkg::K_STAT;
    if (s1_req_r == dotq_pkg::REQ_ARM_AFTER) begin
      cmd.due = sat ? dotq_pkg::S64_MAX : sum[63:0];
    end
    unique case (s1_req_r) inside
      dotq_pkg::REQ_ARM_AT, dotq_pkg::REQ_ARM_AFTER: begin
        cmd.kind   = regd ? dotq_pkg::K_ARM : dotq_pkg::K_STAT;
        cmd.status = regd ? dotq_pkg::ST_OK : dotq_pkg::ST_NOREG;
      end
      dotq_pkg::REQ_DISARM: begin
        cmd.kind   = regd ? dotq_pkg::K_DIS : dotq_pkg::K_STAT;
        cmd.status = regd ? dotq_pkg::ST_OK : dotq_pkg::ST_NOREG;
      end
      dotq_pkg::REQ_DISARM_ALL: cmd.kind = dotq_pkg::K_DALL;
      dotq_pkg::REQ_TICK:       cmd.kind = dotq_pkg::K_TICK;
      dotq_pkg::REQ_QUERY: begin
        cmd.kind   = valid_id ? dotq_pkg::K_QUERY : dotq_pkg::K_STAT;
        cmd.status = valid_id ? dotq_pkg::ST_OK : dotq_pkg::ST_NOREG;
      end
      default: cmd.status = dotq_pkg::ST_BADREQ;
    endcase
  end

endmodule

### rtl/core/dotq_fifo.sv
// Short command queue between the front end and the back end.
module dotq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dotq_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output dotq_pkg::cmd_t dout,
  output logic           empty
);

  localparam int PW = $clog2(dotq_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(dotq_pkg::FIFO_DEPTH + 1);

  dotq_pkg::cmd_t mem [dotq_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wp_r;
  logic [PW-1:0]  rp_r;
  logic [CW-1:0]  cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full    = cnt_r == CW'(dotq_pkg::FIFO_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(dotq_pkg::FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(dotq_pkg::FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= din;
  end

endmodule

### rtl/core/dotq_back.sv
// Back end: keeps the sorted timer list and produces the results.
`include "deadline_ordered_timeout_queue_defines.svh"
module dotq_back #(
  parameter int NUM_TIMERS = dotq_pkg::NUM_TIMERS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  dotq_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output dotq_pkg::res_t res
);

  localparam int IDW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW  = $clog2(NUM_TIMERS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_INS, S_POP, S_EMIT, S_QCAP, S_RESP
  } state_t;

  state_t                     state_r;
  dotq_pkg::cmd_t             cmd_r;
  logic [CW-1:0]              count_r;
  logic [IDW-1:0]             sid_r  [NUM_TIMERS];
  logic signed [63:0]         sdue_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]      act_r;
  logic [NUM_TIMERS-1:0]      fir_r;
  logic [NUM_TIMERS-1:0]      tw_r;
  logic [127:0]               tmem [NUM_TIMERS];
  logic [127:0]               trd_r;
  logic                       trdv_r;
  logic [IDW-1:0]             fbuf_r [dotq_pkg::MAX_FIRE];
  logic [dotq_pkg::FIRE_CW-1:0] n_r;
  logic [dotq_pkg::FIRE_IW-1:0] k_r;
  logic                       qa_r;
  logic                       qf_r;
  logic [63:0]                qs_r;
  logic [63:0]                qd_r;
  logic                       ov_r;
  dotq_pkg::res_t             out_r;

  logic [IDW-1:0]        cidx;
  logic [NUM_TIMERS-1:0] inlist;
  logic [NUM_TIMERS-1:0] match;
  logic [NUM_TIMERS-1:0] ge;
  logic [NUM_TIMERS-1:0] goes_ahead;
  logic [NUM_TIMERS-1:0] lowm;
  logic                  head_fire;
  logic                  out_free;
  logic                  out_load;
  logic                  armed;
  logic                  gt;
  logic [64:0]           diff;
  logic [62:0]           delay;
  logic                  emit_last;

  assign cidx     = IDW'(cmd_r.id);
  assign cmd_pop  = (state_r == S_IDLE) && cmd_valid;
  assign out_free = !ov_r || res_ready;
  assign out_load = ((state_r == S_EMIT) || (state_r == S_RESP)) && out_free;
  assign res_valid = ov_r;
  assign res      = out_r;

  // Every slot compares against the request at once; the list stays sorted.
  always_comb begin
    for (int j = 0; j < NUM_TIMERS; j++) begin
      inlist[j] = CW'(j) < count_r;
      match[j]  = inlist[j] && (sid_r[j] == cidx);
      goes_ahead[j] = !inlist[j] || (cmd_r.due < sdue_r[j]) ||
                      ((cmd_r.due == sdue_r[j]) && (cidx < sid_r[j]));
      lowm      = {NUM_TIMERS{1'b1}} >> (NUM_TIMERS - 1 - j);
      ge[j]     = |(match & lowm);
    end
  end

  assign head_fire = (count_r != '0) && (cmd_r.now >= sdue_r[0]);

  assign armed = count_r != '0;
  assign gt    = sdue_r[0] > cmd_r.now;
  assign diff  = {sdue_r[0][63], sdue_r[0]} - {cmd_r.now[63], cmd_r.now};
  always_comb begin
    if (!armed || !gt) delay = 63'd1;
    else if (diff[63]) delay = dotq_pkg::S64_MAX[62:0];
    else               delay = diff[62:0];
  end

  assign emit_last = (dotq_pkg::FIRE_CW'(k_r) + 1'b1) == n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      act_r   <= '0;
      fir_r   <= '0;
      tw_r    <= '0;
      ov_r    <= 1'b0;
      n_r     <= '0;
      k_r     <= '0;
    end else begin
      if (out_load)       ov_r <= 1'b1;
      else if (res_ready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          qa_r <= 1'b0;
          qf_r <= 1'b0;
          qs_r <= '0;
          qd_r <= '0;
          n_r  <= '0;
          unique case (cmd_r.kind)
            dotq_pkg::K_ARM, dotq_pkg::K_DIS: begin
              if (|match) begin
                for (int j = 0; j < NUM_TIMERS - 1; j++) begin
                  if (ge[j]) begin
                    sid_r[j]  <= sid_r[j+1];
                    sdue_r[j] <= sdue_r[j+1];
                  end
                end
                count_r     <= count_r - 1'b1;
                act_r[cidx] <= 1'b0;
              end
              if (cmd_r.kind == dotq_pkg::K_DIS && !cmd_r.keep) fir_r[cidx] <= 1'b0;
              state_r <= (cmd_r.kind == dotq_pkg::K_ARM) ? S_INS : S_RESP;
            end
            dotq_pkg::K_DALL: begin
              count_r <= '0;
              act_r   <= '0;
              if (!cmd_r.keep) fir_r <= '0;
              state_r <= S_RESP;
            end
            dotq_pkg::K_TICK:  state_r <= S_POP;
            dotq_pkg::K_QUERY: begin
              trdv_r  <= tw_r[cidx];
              state_r <= S_QCAP;
            end
            default: state_r <= S_RESP;
          endcase
        end
        S_INS: begin
          for (int j = 0; j < NUM_TIMERS; j++) begin
            if (goes_ahead[j] && (j == 0 || !goes_ahead[(j > 0) ? j - 1 : 0])) begin
              sid_r[j]  <= cidx;
              sdue_r[j] <= cmd_r.due;
            end else if (goes_ahead[j] && j > 0) begin
              sid_r[j]  <= sid_r[(j > 0) ? j - 1 : 0];
              sdue_r[j] <= sdue_r[(j > 0) ? j - 1 : 0];
            end
          end
          count_r     <= count_r + 1'b1;
          act_r[cidx] <= 1'b1;
          fir_r[cidx] <= 1'b0;
          tw_r[cidx]  <= 1'b1;
          state_r     <= S_RESP;
        end
        S_POP: begin
          if (head_fire && n_r < dotq_pkg::FIRE_CW'(dotq_pkg::MAX_FIRE)) begin
            for (int j = 0; j < NUM_TIMERS - 1; j++) begin
              sid_r[j]  <= sid_r[j+1];
              sdue_r[j] <= sdue_r[j+1];
            end
            count_r          <= count_r - 1'b1;
            act_r[sid_r[0]]  <= 1'b0;
            fir_r[sid_r[0]]  <= 1'b1;
            fbuf_r[n_r[dotq_pkg::FIRE_IW-1:0]] <= sid_r[0];
            n_r              <= n_r + 1'b1;
          end else if (n_r == '0) begin
            state_r <= S_RESP;
          end else begin
            k_r     <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_r.status <= dotq_pkg::ST_OK;
            out_r.fv     <= 1'b1;
            out_r.fid    <= 4'(fbuf_r[k_r]);
            out_r.last   <= emit_last;
            out_r.armed  <= armed;
            out_r.delay  <= delay;
            out_r.qa     <= 1'b0;
            out_r.qf     <= 1'b0;
            out_r.qs     <= '0;
            out_r.qd     <= '0;
            k_r          <= k_r + 1'b1;
            if (emit_last) state_r <= S_IDLE;
          end
        end
        S_QCAP: begin
          qa_r <= act_r[cidx];
          qf_r <= fir_r[cidx];
          qs_r <= trdv_r ? trd_r[127:64] : '0;
          qd_r <= trdv_r ? trd_r[63:0] : '0;
          if (fir_r[cidx] && cmd_r.clr) fir_r[cidx] <= 1'b0;
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_r.status <= cmd_r.status;
            out_r.fv     <= 1'b0;
            out_r.fid    <= '0;
            out_r.last   <= 1'b1;
            out_r.armed  <= armed;
            out_r.delay  <= delay;
            out_r.qa     <= qa_r;
            out_r.qf     <= qf_r;
            out_r.qs     <= qs_r;
            out_r.qd     <= qd_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Arm and deadline times per timer, read only by queries.
  always_ff @(posedge clk) begin
    if (state_r == S_INS) tmem[cidx] <= {cmd_r.now, cmd_r.due};
    if (state_r == S_EXEC) trd_r <= tmem[cidx];
  end

  `DOTQ_ASSERT(a_count_range, count_r <= CW'(NUM_TIMERS), "active count exceeds timer count")
  `DOTQ_ASSERT(a_count_bits, $countones(act_r) == 32'(count_r), "active bits disagree with count")
  `DOTQ_ASSERT_IMP(a_fired_ok, ov_r && out_r.fv, out_r.status == dotq_pkg::ST_OK, "bad fired status")
  `DOTQ_ASSERT_IMP(a_emit_nonempty, state_r == S_EMIT, n_r != '0, "emitting with no fired timers")

endmodule
